// File: hw/rtl/oct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orientation coordinate transform package
// Codes, widths, the transformed-item record and the clamp helper.
// ----------------------------------------------------------------------------
package oct_pkg;

	localparam int DEFAULT_MAX_DIMENSION = 16384;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 15;
	localparam int DIM_IN_W    = 15;
	localparam int OFFSET_IN_W = 14;
	localparam int COORD_W     = 32;
	localparam int CALC_W      = 34;
	localparam int BOFF_W      = 30;
	localparam int LIN_MIN_W   = BOFF_W - 2;

	localparam logic [CFG_INDEX_W-1:0] REG_CROP_WIDTH  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CROP_HEIGHT = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CROP_LEFT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CROP_TOP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIENT_MODE = 3'd4;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_DAMAGE = 2'd1;
	localparam logic [1:0] KIND_CURSOR = 2'd2;

	localparam logic [2:0] MODE_UPRIGHT  = 3'd0;
	localparam logic [2:0] MODE_ROT90    = 3'd1;
	localparam logic [2:0] MODE_ROT180   = 3'd2;
	localparam logic [2:0] MODE_ROT270   = 3'd3;
	localparam logic [2:0] MODE_FLIPPED  = 3'd4;
	localparam logic [2:0] MODE_FLIP90   = 3'd5;
	localparam logic [2:0] MODE_FLIP180  = 3'd6;
	localparam logic [2:0] MODE_FLIP270  = 3'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [DIM_IN_W-1:0]       width;
		logic [DIM_IN_W-1:0]       height;
		logic                      out_of_range;
		logic                      use_offset;
	} xform_t;

	function automatic logic signed [COORD_W-1:0] clamp32(input logic signed [CALC_W-1:0] v);
		logic signed [CALC_W-1:0] lo;
		logic signed [CALC_W-1:0] hi;
		lo = -(CALC_W'(64'sd2147483648));
		hi = CALC_W'(64'sd2147483647);
		if (v < lo) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else if (v > hi) begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/orientation_coordinate_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Orientation coordinate transform
// Maps pixel, damage and cursor coordinates through one of eight orientations.
// ----------------------------------------------------------------------------
// Each accepted item passes through the input register, then the result register.
// Throughput: one item per cycle; the input and result registers form a
// two-stage pipeline that advances whenever the output is taken or empty.
// The transform and the byte offset multiplier sit between the two registers.
// Reset clears all valid bits and returns the registers to a 1 x 1 upright crop.

module orientation_coordinate_transform #(
	parameter int MAX_DIMENSION = oct_pkg::DEFAULT_MAX_DIMENSION
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 cfg_we,
	input  wire logic [oct_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [oct_pkg::CFG_DATA_W-1:0]       cfg_data,

	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           kind,
	input  wire logic signed [oct_pkg::COORD_W-1:0]   pos_x,
	input  wire logic signed [oct_pkg::COORD_W-1:0]   pos_y,
	input  wire logic [oct_pkg::DIM_IN_W-1:0]         rect_width,
	input  wire logic [oct_pkg::DIM_IN_W-1:0]         rect_height,

	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [oct_pkg::COORD_W-1:0]        out_x,
	output logic signed [oct_pkg::COORD_W-1:0]        out_y,
	output logic [oct_pkg::DIM_IN_W-1:0]              out_width,
	output logic [oct_pkg::DIM_IN_W-1:0]              out_height,
	output logic [oct_pkg::BOFF_W-1:0]                byte_offset,
	output logic                                      out_of_range
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int SUM_W = 2 * DIM_W + 1;
	localparam int LIN_W = (SUM_W > oct_pkg::LIN_MIN_W) ? SUM_W : oct_pkg::LIN_MIN_W;
	localparam int CW    = oct_pkg::CALC_W;

	logic [oct_pkg::DIM_IN_W-1:0]    crop_width_q;
	logic [oct_pkg::DIM_IN_W-1:0]    crop_height_q;
	logic [oct_pkg::OFFSET_IN_W-1:0] crop_left_q;
	logic [oct_pkg::OFFSET_IN_W-1:0] crop_top_q;
	logic [2:0]                      orient_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_width_q  <= oct_pkg::DIM_IN_W'(1);
			crop_height_q <= oct_pkg::DIM_IN_W'(1);
			crop_left_q   <= '0;
			crop_top_q    <= '0;
			orient_mode_q <= oct_pkg::MODE_UPRIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				oct_pkg::REG_CROP_WIDTH:  crop_width_q  <= cfg_data;
				oct_pkg::REG_CROP_HEIGHT: crop_height_q <= cfg_data;
				oct_pkg::REG_CROP_LEFT:   crop_left_q   <= cfg_data[oct_pkg::OFFSET_IN_W-1:0];
				oct_pkg::REG_CROP_TOP:    crop_top_q    <= cfg_data[oct_pkg::OFFSET_IN_W-1:0];
				oct_pkg::REG_ORIENT_MODE: orient_mode_q <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline flow control.
	logic valid_s1;
	logic out_valid_q;
	logic adv_out;
	logic adv_s1;

	assign adv_out  = !out_valid_q || !out_stall;
	assign adv_s1   = !valid_s1 || adv_out;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Input register.
	logic [1:0]                        kind_s1;
	logic signed [oct_pkg::COORD_W-1:0] pos_x_s1;
	logic signed [oct_pkg::COORD_W-1:0] pos_y_s1;
	logic [oct_pkg::DIM_IN_W-1:0]      rect_width_s1;
	logic [oct_pkg::DIM_IN_W-1:0]      rect_height_s1;

	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			kind_s1        <= kind;
			pos_x_s1       <= pos_x;
			pos_y_s1       <= pos_y;
			rect_width_s1  <= rect_width;
			rect_height_s1 <= rect_height;
		end
	end

	// Saturated dimensions.
	logic [DIM_W-1:0] w_sat;
	logic [DIM_W-1:0] h_sat;
	logic [DIM_W-1:0] rw_sat;
	logic [DIM_W-1:0] rh_sat;

	assign w_sat  = (32'(crop_width_q) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION)
		: DIM_W'(crop_width_q);
	assign h_sat  = (32'(crop_height_q) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION)
		: DIM_W'(crop_height_q);
	assign rw_sat = (32'(rect_width_s1) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION)
		: DIM_W'(rect_width_s1);
	assign rh_sat = (32'(rect_height_s1) > MAX_DIMENSION) ? DIM_W'(MAX_DIMENSION)
		: DIM_W'(rect_height_s1);

	logic signed [CW-1:0] w_x;
	logic signed [CW-1:0] h_x;
	logic signed [CW-1:0] rw_x;
	logic signed [CW-1:0] rh_x;
	logic signed [CW-1:0] px;
	logic signed [CW-1:0] py;
	logic signed [CW-1:0] sx;
	logic signed [CW-1:0] sy;
	logic signed [CW-1:0] vw;
	logic signed [CW-1:0] vh;
	logic signed [CW-1:0] wm1_px;
	logic signed [CW-1:0] wm1_py;
	logic signed [CW-1:0] hm1_px;
	logic signed [CW-1:0] hm1_py;
	logic signed [CW-1:0] wm1_sx;
	logic signed [CW-1:0] hm1_sy;
	logic signed [CW-1:0] rx;
	logic signed [CW-1:0] ry;
	logic signed [CW-1:0] cx;
	logic signed [CW-1:0] cy;
	logic                 swap;
	logic                 pix_bad;
	logic                 dmg_bad;

	assign w_x    = $signed(CW'(w_sat));
	assign h_x    = $signed(CW'(h_sat));
	assign rw_x   = $signed(CW'(rw_sat));
	assign rh_x   = $signed(CW'(rh_sat));
	assign px     = CW'(pos_x_s1);
	assign py     = CW'(pos_y_s1);
	assign sx     = px - $signed(CW'(crop_left_q));
	assign sy     = py - $signed(CW'(crop_top_q));
	assign swap   = orient_mode_q[0];
	assign vw     = swap ? h_x : w_x;
	assign vh     = swap ? w_x : h_x;
	assign wm1_px = w_x - CW'(1) - px;
	assign wm1_py = w_x - CW'(1) - py;
	assign hm1_px = h_x - CW'(1) - px;
	assign hm1_py = h_x - CW'(1) - py;
	assign wm1_sx = w_x - CW'(1) - sx;
	assign hm1_sy = h_x - CW'(1) - sy;
	assign rx     = w_x - px - rw_x;
	assign ry     = h_x - py - rh_x;

	assign pix_bad = pos_x_s1[oct_pkg::COORD_W-1] || pos_y_s1[oct_pkg::COORD_W-1]
		|| (px >= vw) || (py >= vh);
	assign dmg_bad = (rw_sat == '0) || (rh_sat == '0)
		|| pos_x_s1[oct_pkg::COORD_W-1] || pos_y_s1[oct_pkg::COORD_W-1]
		|| (px > w_x) || (py > h_x) || (rw_x > w_x - px) || (rh_x > h_x - py);

	oct_pkg::xform_t xf;

	always_comb begin
		xf = '0;
		cx = '0;
		cy = '0;
		unique case (kind_s1)
			oct_pkg::KIND_PIXEL: begin
				if (pix_bad) begin
					xf.out_of_range = 1'b1;
				end else begin
					unique case (orient_mode_q)
						oct_pkg::MODE_UPRIGHT: begin cx = px;     cy = py;     end
						oct_pkg::MODE_ROT90:   begin cx = py;     cy = hm1_px; end
						oct_pkg::MODE_ROT180:  begin cx = wm1_px; cy = hm1_py; end
						oct_pkg::MODE_ROT270:  begin cx = wm1_py; cy = px;     end
						oct_pkg::MODE_FLIPPED: begin cx = wm1_px; cy = py;     end
						oct_pkg::MODE_FLIP90:  begin cx = py;     cy = px;     end
						oct_pkg::MODE_FLIP180: begin cx = px;     cy = hm1_py; end
						oct_pkg::MODE_FLIP270: begin cx = wm1_py; cy = hm1_px; end
					endcase
					xf.x          = cx[oct_pkg::COORD_W-1:0];
					xf.y          = cy[oct_pkg::COORD_W-1:0];
					xf.use_offset = 1'b1;
				end
			end
			oct_pkg::KIND_DAMAGE: begin
				if (dmg_bad) begin
					xf.out_of_range = 1'b1;
				end else begin
					unique case (orient_mode_q)
						oct_pkg::MODE_UPRIGHT: begin cx = px; cy = py; end
						oct_pkg::MODE_ROT90:   begin cx = ry; cy = px; end
						oct_pkg::MODE_ROT180:  begin cx = rx; cy = ry; end
						oct_pkg::MODE_ROT270:  begin cx = py; cy = rx; end
						oct_pkg::MODE_FLIPPED: begin cx = rx; cy = py; end
						oct_pkg::MODE_FLIP90:  begin cx = py; cy = px; end
						oct_pkg::MODE_FLIP180: begin cx = px; cy = ry; end
						oct_pkg::MODE_FLIP270: begin cx = ry; cy = rx; end
					endcase
					xf.x      = cx[oct_pkg::COORD_W-1:0];
					xf.y      = cy[oct_pkg::COORD_W-1:0];
					xf.width  = oct_pkg::DIM_IN_W'(swap ? rh_sat : rw_sat);
					xf.height = oct_pkg::DIM_IN_W'(swap ? rw_sat : rh_sat);
				end
			end
			oct_pkg::KIND_CURSOR: begin
				unique case (orient_mode_q)
					oct_pkg::MODE_UPRIGHT: begin cx = sx;     cy = sy;     end
					oct_pkg::MODE_ROT90:   begin cx = hm1_sy; cy = sx;     end
					oct_pkg::MODE_ROT180:  begin cx = wm1_sx; cy = hm1_sy; end
					oct_pkg::MODE_ROT270:  begin cx = sy;     cy = wm1_sx; end
					oct_pkg::MODE_FLIPPED: begin cx = wm1_sx; cy = sy;     end
					oct_pkg::MODE_FLIP90:  begin cx = sy;     cy = sx;     end
					oct_pkg::MODE_FLIP180: begin cx = sx;     cy = hm1_sy; end
					oct_pkg::MODE_FLIP270: begin cx = hm1_sy; cy = wm1_sx; end
				endcase
				xf.x = oct_pkg::clamp32(cx);
				xf.y = oct_pkg::clamp32(cy);
			end
			default: begin
				xf.out_of_range = 1'b1;
			end
		endcase
	end

	// Byte offset: (y * W + x) * 4 for pixels, zero otherwise, wrapped to the offset width.
	logic [2*DIM_W-1:0] prod;
	logic [LIN_W-1:0]   lin;
	logic [oct_pkg::BOFF_W-1:0] boff;

	assign prod = {{DIM_W{1'b0}}, xf.y[DIM_W-1:0]} * {{DIM_W{1'b0}}, w_sat};
	assign lin  = LIN_W'(prod) + LIN_W'(xf.x[DIM_W-1:0]);
	assign boff = xf.use_offset ? {lin[oct_pkg::LIN_MIN_W-1:0], 2'b00} : '0;

	// Result register.
	logic signed [oct_pkg::COORD_W-1:0] out_x_q;
	logic signed [oct_pkg::COORD_W-1:0] out_y_q;
	logic [oct_pkg::DIM_IN_W-1:0]       out_width_q;
	logic [oct_pkg::DIM_IN_W-1:0]       out_height_q;
	logic [oct_pkg::BOFF_W-1:0]         byte_offset_q;
	logic                               out_of_range_q;

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_out) begin
			out_x_q        <= xf.x;
			out_y_q        <= xf.y;
			out_width_q    <= xf.width;
			out_height_q   <= xf.height;
			byte_offset_q  <= boff;
			out_of_range_q <= xf.out_of_range;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_x        = out_x_q;
	assign out_y        = out_y_q;
	assign out_width    = out_width_q;
	assign out_height   = out_height_q;
	assign byte_offset  = byte_offset_q;
	assign out_of_range = out_of_range_q;

endmodule
`default_nettype wire
